### rtl/partial_reliability_arq_sender_unit_assert.svh
// Assertion macros for the ARQ sender unit
`ifndef PARTIAL_RELIABILITY_ARQ_SENDER_UNIT_ASSERT_SVH
`define PARTIAL_RELIABILITY_ARQ_SENDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PRAS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PRAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRAS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define PRAS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/pras_pkg.sv
// Shared types and constants for the ARQ sender unit
package pras_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int LOSS_SCALE      = 100;

    localparam logic [6:0]  PCT_RESET = 7'd40;
    localparam logic [31:0] OUT_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_SUBMIT  = 2'd0;
    localparam logic [1:0] CMD_REPLY   = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_TX   = 2'd1;
    localparam logic [1:0] ACT_ACK  = 2'd2;
    localparam logic [1:0] ACT_LOSS = 2'd3;

    typedef enum logic [3:0] {
        KIND_NONE    = 4'b0001,
        KIND_SUBMIT  = 4'b0010,
        KIND_REPLY   = 4'b0100,
        KIND_TIMEOUT = 4'b1000
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WAIT = 2'b10
    } state_t;

    typedef struct packed {
        kind_t kind;
        logic  ack_flag;
        logic  ack_bit;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### rtl/partial_reliability_arq_sender_unit.sv
// Top level of the stop-and-wait ARQ sender with partial reliability
// Takes one event beat per cycle while s_ready is high and returns one result
// beat per event, in order. A beat passes a classify register, a two-entry
// queue and the result register. The protocol engine sustains one beat per
// cycle while m_ready holds, and updates the sequence bit, the counters and the
// loss-tolerance compare (percentage times sent count) as each beat is popped.
// Reset restores the loss percentage to 40.
`include "partial_reliability_arq_sender_unit_assert.svh"

module partial_reliability_arq_sender_unit #(
    parameter int COUNT_WIDTH = pras_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_reply_ack_flag,
    input  logic        s_reply_ack_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic        m_tx_seq_bit,
    output logic [31:0] m_messages_sent,
    output logic [31:0] m_messages_lost
);
    import pras_pkg::*;

    logic   push;
    item_t  push_item;
    logic   pop;
    item_t  pop_item;
    qstat_t q_stat;
    logic   hold_valid;

    pras_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_reply_ack_flag (s_reply_ack_flag),
        .s_reply_ack_bit  (s_reply_ack_bit),
        .push             (push),
        .push_item        (push_item),
        .q_stat           (q_stat),
        .hold_valid       (hold_valid)
    );

    pras_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    pras_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .pop_item        (pop_item),
        .q_stat          (q_stat),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_tx_seq_bit    (m_tx_seq_bit),
        .m_messages_sent (m_messages_sent),
        .m_messages_lost (m_messages_lost)
    );

    `PRAS_ASSERT_NEXT(a_front_load, aclk, aresetn, s_valid && s_ready, hold_valid)
    `PRAS_ASSERT_SAME(a_push_room, aclk, aresetn, push, !q_stat.full)
    `PRAS_ASSERT_SAME(a_pop_data, aclk, aresetn, pop, !q_stat.empty)
    `PRAS_ASSERT_SAME(a_txbit_zero, aclk, aresetn, m_valid && (m_action != ACT_TX), !m_tx_seq_bit)

endmodule

### rtl/pras_front.sv
// Input stage: accept event beats and classify them
module pras_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic              s_reply_ack_flag,
    input  logic              s_reply_ack_bit,
    output logic              push,
    output pras_pkg::item_t   push_item,
    input  pras_pkg::qstat_t  q_stat,
    output logic              hold_valid
);
    import pras_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign push       = hold_valid_reg && !q_stat.full;
    assign s_ready    = !hold_valid_reg || !q_stat.full;
    assign accept     = s_valid && s_ready;
    assign push_item  = item_reg;
    assign hold_valid = hold_valid_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb begin
        item_next.ack_flag = s_reply_ack_flag;
        item_next.ack_bit  = s_reply_ack_bit;
        case (s_cmd)
            CMD_SUBMIT:  item_next.kind = KIND_SUBMIT;
            CMD_REPLY:   item_next.kind = KIND_REPLY;
            CMD_TIMEOUT: item_next.kind = KIND_TIMEOUT;
            default:     item_next.kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/pras_queue.sv
// Two-entry queue between the front and back stages
module pras_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pras_pkg::item_t   push_item,
    input  logic              pop,
    output pras_pkg::item_t   pop_item,
    output pras_pkg::qstat_t  q_stat
);
    import pras_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/pras_back.sv
// Protocol engine: sequence bit, counters, loss test and result register
module pras_back #(
    parameter int COUNT_WIDTH = pras_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data,
    input  pras_pkg::item_t   pop_item,
    input  pras_pkg::qstat_t  q_stat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_action,
    output logic              m_tx_seq_bit,
    output logic [31:0]       m_messages_sent,
    output logic [31:0]       m_messages_lost
);
    import pras_pkg::*;

    localparam int MW = COUNT_WIDTH + 8;
    localparam int XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    function automatic logic [31:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
        logic [XW-1:0] ext;
        begin
            ext = XW'(v);
            return (ext > XW'(OUT_MAX)) ? OUT_MAX : ext[31:0];
        end
    endfunction

    logic [6:0]             pct_reg;
    state_t                 state_reg;
    state_t                 state_next;
    logic                   seq_reg;
    logic                   seq_next;
    logic [COUNT_WIDTH-1:0] sent_reg;
    logic [COUNT_WIDTH-1:0] sent_next;
    logic [COUNT_WIDTH-1:0] lost_reg;
    logic [COUNT_WIDTH-1:0] lost_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [1:0]             action_reg;
    logic [1:0]             action_next;
    logic                   txbit_reg;
    logic                   txbit_next;
    logic [31:0]            sent_out_reg;
    logic [31:0]            lost_out_reg;
    logic [COUNT_WIDTH:0]   cand;
    logic [MW-1:0]          loss_lhs;
    logic [MW-1:0]          loss_rhs;
    logic                   tolerate;
    logic                   busy;

    assign pop  = !q_stat.empty && (!m_valid_reg || m_ready);
    assign busy = (state_reg == ST_WAIT);

    assign cand     = {1'b0, lost_reg} + (COUNT_WIDTH + 1)'(1);
    assign loss_lhs = MW'(cand) * MW'(LOSS_SCALE);
    assign loss_rhs = MW'(pct_reg) * MW'(sent_reg);
    assign tolerate = (loss_lhs < loss_rhs);

    always_comb begin
        state_next  = state_reg;
        seq_next    = seq_reg;
        sent_next   = sent_reg;
        lost_next   = lost_reg;
        action_next = ACT_NONE;
        txbit_next  = 1'b0;
        case (pop_item.kind)
            KIND_SUBMIT: begin
                if (!busy) begin
                    if (sent_reg != {COUNT_WIDTH{1'b1}}) begin
                        sent_next = sent_reg + COUNT_WIDTH'(1);
                    end
                    state_next  = ST_WAIT;
                    action_next = ACT_TX;
                    txbit_next  = seq_reg;
                end
            end
            KIND_REPLY: begin
                if (busy) begin
                    if (pop_item.ack_flag && (pop_item.ack_bit == !seq_reg)) begin
                        seq_next    = !seq_reg;
                        state_next  = ST_IDLE;
                        action_next = ACT_ACK;
                    end else begin
                        action_next = ACT_TX;
                        txbit_next  = seq_reg;
                    end
                end
            end
            KIND_TIMEOUT: begin
                if (busy) begin
                    if (tolerate) begin
                        lost_next   = cand[COUNT_WIDTH] ? lost_reg : cand[COUNT_WIDTH-1:0];
                        seq_next    = !seq_reg;
                        state_next  = ST_IDLE;
                        action_next = ACT_LOSS;
                    end else begin
                        action_next = ACT_TX;
                        txbit_next  = seq_reg;
                    end
                end
            end
            default: begin
                action_next = ACT_NONE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg     <= PCT_RESET;
            state_reg   <= ST_IDLE;
            seq_reg     <= 1'b0;
            sent_reg    <= '0;
            lost_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pct_reg <= cfg_wr_data;
            end
            if (pop) begin
                state_reg <= state_next;
                seq_reg   <= seq_next;
                sent_reg  <= sent_next;
                lost_reg  <= lost_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            action_reg   <= action_next;
            txbit_reg    <= txbit_next;
            sent_out_reg <= clip_out(sent_next);
            lost_out_reg <= clip_out(lost_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = action_reg;
    assign m_tx_seq_bit    = txbit_reg;
    assign m_messages_sent = sent_out_reg;
    assign m_messages_lost = lost_out_reg;

endmodule

### tb/tb_partial_reliability_arq_sender_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the partial-reliability stop-and-wait ARQ sender
module tb_partial_reliability_arq_sender_unit;
    import pras_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 220;

    typedef struct packed {
        logic [1:0]  action;
        logic        tx_seq_bit;
        logic [31:0] sent;
        logic [31:0] lost;
    } arq_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_SUBMIT;
    logic        s_reply_ack_flag = 1'b0;
    logic        s_reply_ack_bit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_action;
    logic        m_tx_seq_bit;
    logic [31:0] m_messages_sent;
    logic [31:0] m_messages_lost;

    logic [6:0]  loss_pct = PCT_RESET;
    logic        seq_bit = 1'b0;
    logic        awaiting_ack = 1'b0;
    logic [31:0] sent_count = '0;
    logic [31:0] lost_count = '0;

    arq_result_t expected_results[$];
    int          mismatch_count = 0;
    int          beats_counted = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;

    partial_reliability_arq_sender_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_reply_ack_flag (s_reply_ack_flag),
        .s_reply_ack_bit  (s_reply_ack_bit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_tx_seq_bit     (m_tx_seq_bit),
        .m_messages_sent  (m_messages_sent),
        .m_messages_lost  (m_messages_lost)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("partial_reliability_arq_sender_unit test failed");
            $finish;
        end
    end

    function automatic int gap_cycles();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic arq_result_t predict_arq_event(input logic [1:0] cmd,
                                                      input logic ack_flag,
                                                      input logic ack_bit);
        arq_result_t res;
        logic [63:0] lost_scaled;
        logic [63:0] allowed;
        logic [32:0] lost_next;
        res.action = ACT_NONE;
        res.tx_seq_bit = 1'b0;
        case (cmd)
            CMD_SUBMIT: begin
                if (!awaiting_ack) begin
                    if (sent_count != OUT_MAX) begin
                        sent_count = sent_count + 1;
                    end
                    awaiting_ack = 1'b1;
                    res.action = ACT_TX;
                    res.tx_seq_bit = seq_bit;
                end
            end
            CMD_REPLY: begin
                if (awaiting_ack) begin
                    if (ack_flag && (ack_bit == ~seq_bit)) begin
                        seq_bit = ~seq_bit;
                        awaiting_ack = 1'b0;
                        res.action = ACT_ACK;
                    end else begin
                        res.action = ACT_TX;
                        res.tx_seq_bit = seq_bit;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (awaiting_ack) begin
                    lost_next = {1'b0, lost_count} + 33'd1;
                    lost_scaled = 64'(lost_next) * 64'(LOSS_SCALE);
                    allowed = 64'(loss_pct) * 64'(sent_count);
                    if (lost_scaled < allowed) begin
                        lost_count = lost_next[32] ? OUT_MAX : lost_next[31:0];
                        seq_bit = ~seq_bit;
                        awaiting_ack = 1'b0;
                        res.action = ACT_LOSS;
                    end else begin
                        res.action = ACT_TX;
                        res.tx_seq_bit = seq_bit;
                    end
                end
            end
            default: begin
            end
        endcase
        res.sent = sent_count;
        res.lost = lost_count;
        return res;
    endfunction

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
            rx_hold <= gap_cycles() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        arq_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: action %0d", m_action);
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_action !== exp_res.action) begin
                    $error("action: expected %0d, actual %0d", exp_res.action, m_action);
                    mismatch_count++;
                end
                if (m_tx_seq_bit !== exp_res.tx_seq_bit) begin
                    $error("tx_seq_bit: expected %0d, actual %0d",
                           exp_res.tx_seq_bit, m_tx_seq_bit);
                    mismatch_count++;
                end
                if (m_messages_sent !== exp_res.sent) begin
                    $error("messages_sent: expected %0d, actual %0d",
                           exp_res.sent, m_messages_sent);
                    mismatch_count++;
                end
                if (m_messages_lost !== exp_res.lost) begin
                    $error("messages_lost: expected %0d, actual %0d",
                           exp_res.lost, m_messages_lost);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_event(input logic [1:0] cmd, input logic ack_flag,
                              input logic ack_bit);
        int gap;
        arq_result_t res;
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? gap_cycles() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_reply_ack_flag <= ack_flag;
        s_reply_ack_bit <= ack_bit;
        do @(posedge aclk); while (!s_ready);
        res = predict_arq_event(cmd, ack_flag, ack_bit);
        expected_results.push_back(res);
        if (res.action != ACT_NONE) begin
            beats_counted++;
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_loss_pct(input logic [6:0] pct);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pct;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        loss_pct = pct;
    endtask

    task automatic run_message();
        int  r;
        logic flag;
        send_event(CMD_SUBMIT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (awaiting_ack) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_event(CMD_REPLY, 1'b1, ~seq_bit);
            end else if (r < 55) begin
                flag = 1'($urandom_range(0, 1));
                send_event(CMD_REPLY, flag, flag ? seq_bit : 1'($urandom_range(0, 1)));
            end else if (r < 93) begin
                send_event(CMD_TIMEOUT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_idle_events();
        send_event(CMD_RESERVED, 1'b1, 1'b1);
        send_event(CMD_REPLY, 1'b1, 1'b1);
        send_event(CMD_TIMEOUT, 1'b0, 1'b0);
    endtask

    task automatic test_reply_handling();
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_SUBMIT, 1'b1, 1'b1);
        send_event(CMD_RESERVED, 1'b0, 1'b0);
        send_event(CMD_REPLY, 1'b0, 1'b0);
        send_event(CMD_REPLY, 1'b0, 1'b1);
        send_event(CMD_REPLY, 1'b1, 1'b0);
        send_event(CMD_REPLY, 1'b1, 1'b1);
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_REPLY, 1'b1, 1'b1);
        send_event(CMD_REPLY, 1'b1, 1'b0);
    endtask

    task automatic test_timeout_tolerance();
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_TIMEOUT, 1'b0, 1'b0);
        send_event(CMD_TIMEOUT, 1'b1, 1'b1);
        send_event(CMD_REPLY, 1'b1, ~seq_bit);
        write_loss_pct(7'd0);
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_TIMEOUT, 1'b0, 1'b0);
        send_event(CMD_REPLY, 1'b1, ~seq_bit);
        write_loss_pct(7'd127);
        send_event(CMD_SUBMIT, 1'b1, 1'b0);
        send_event(CMD_TIMEOUT, 1'b0, 1'b1);
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_TIMEOUT, 1'b0, 1'b0);
        write_loss_pct(7'd100);
        send_event(CMD_SUBMIT, 1'b0, 1'b0);
        send_event(CMD_TIMEOUT, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          target;
        logic [6:0]  pct;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: pct = PCT_RESET;
                1: pct = 7'd0;
                2: pct = 7'd100;
                3: pct = 7'd127;
                4: pct = 7'($urandom_range(0, 127));
                default: pct = 7'($urandom_range(1, 99));
            endcase
            write_loss_pct(pct);
            tx_idle_en = (phase != 0);
            rx_idle_en = (phase != 0);
            target = beats_counted + PHASE_ITEMS;
            while (beats_counted < target) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end else begin
                    run_message();
                end
                if ($urandom_range(0, 99) < 2) begin
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_events();
        test_reply_handling();
        test_timeout_tolerance();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0) begin
            $display("partial_reliability_arq_sender_unit test passed");
        end else begin
            $display("partial_reliability_arq_sender_unit test failed");
        end
        $finish;
    end

endmodule
